// ===== src/lpd_pkg.sv =====
// Package for the line peak of pixel difference unit.
// Field widths, register indexes and the pixel difference helpers.
// No dependencies.
package lpd_pkg;

    // payload field widths
    localparam int POS_W   = 10;
    localparam int CHAN_W  = 8;
    localparam int SUM_W   = 10;
    localparam int PEAK_W  = 8;
    localparam int REG_W   = 11;
    // wide enough for any region limit up to 8192
    localparam int LIM_W   = 14;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;

    // floor(x / 3) for x < 768 as (x * 683) >> 11
    localparam int RECIP_W     = 10;
    localparam int RECIP_SHIFT = 11;
    localparam logic [RECIP_W-1:0] RECIP_3 = 10'd683;
    localparam int PROD_W = SUM_W + RECIP_W;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODE = 2'd0,
        CFG_ROWS = 2'd1,
        CFG_COLS = 2'd2,
        CFG_NONE = 2'd3
    } cfg_index_t;

    // running peak entry as kept in the column store
    typedef struct packed {
        logic [POS_W-1:0]  place;
        logic [PEAK_W-1:0] peak;
    } peak_entry_t;

    localparam int ENTRY_W = POS_W + PEAK_W;

    // absolute difference of two channel values
    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // sum of the three channel differences, at most 765
    function automatic logic [SUM_W-1:0] diff_sum(
        input logic [CHAN_W-1:0] rb, input logic [CHAN_W-1:0] rg,
        input logic [CHAN_W-1:0] rr, input logic [CHAN_W-1:0] cb,
        input logic [CHAN_W-1:0] cg, input logic [CHAN_W-1:0] cr);
        return SUM_W'(abs_diff(cb, rb)) + SUM_W'(abs_diff(cg, rg))
             + SUM_W'(abs_diff(cr, rr));
    endfunction

endpackage

// ===== src/lpd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
// No dependencies.
module lpd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/line_peak_of_pixel_difference_unit.sv =====
// Line peak of pixel difference: tracks the largest mean absolute BGR
// difference per row or per column and reports it at the end of each line.
// Depends on lpd_pkg and lpd_ram.
//
// Usage:
//   s_ channel: one pixel pair per transfer, raster order. Pairs outside
//   the region set by rows_in_use / cols_in_use are taken and dropped.
//   m_ channel: one result transfer when a pair closes a line (last column
//   in row mode, last row in column mode).
//   cfg_ port: write per_column_mode (0), rows_in_use (1), cols_in_use (2)
//   only while no pair is in flight.
// Throughput: one pair per cycle while s_tready is high. Column peaks live
//   in one RAM (read at acceptance, written when the pair leaves stage 1);
//   a same-column read that meets that write is served from a bypass
//   register. m_tvalid comes from the output register behind stage 1.
// Stall: a pending result sits in the output register while new pairs keep
//   flowing; s_tready drops only when a second line-closing pair is ready
//   and the output register is still held.
// Reset: control state and the row peak clear, registers take their reset
//   values; the column store needs no clearing, each column starts at row 0.
module line_peak_of_pixel_difference_unit #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  lpd_pkg::cfg_index_t             cfg_index,
    input  logic [lpd_pkg::REG_W-1:0]       cfg_wdata,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // row_pos, col_pos, ref_blue, ref_green, ref_red, cmp_blue, cmp_green,
    // cmp_red, zero pad (lowest bit up)
    input  logic [lpd_pkg::IN_DATA_W-1:0]   s_tdata,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // line_index, peak_value, peak_position, zero pad (lowest bit up)
    output logic [lpd_pkg::OUT_DATA_W-1:0]  m_tdata
);

    import lpd_pkg::*;

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [LIM_W-1:0] MAX_ROWS_L = LIM_W'(MAX_ROWS);
    localparam logic [LIM_W-1:0] MAX_COLS_L = LIM_W'(MAX_COLS);

    // configuration registers
    logic             mode_reg;
    logic [REG_W-1:0] rows_reg;
    logic [REG_W-1:0] cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            rows_reg <= REG_W'(1024);
            cols_reg <= REG_W'(1024);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MODE: mode_reg <= cfg_wdata[0];
                CFG_ROWS: rows_reg <= cfg_wdata;
                CFG_COLS: cols_reg <= cfg_wdata;
                default:  ;
            endcase
        end
    end

    // input field unpack
    logic [POS_W-1:0]  in_row, in_col;
    logic [CHAN_W-1:0] rb, rg, rr, cb, cg, cr;

    assign in_row = s_tdata[9:0];
    assign in_col = s_tdata[19:10];
    assign rb     = s_tdata[27:20];
    assign rg     = s_tdata[35:28];
    assign rr     = s_tdata[43:36];
    assign cb     = s_tdata[51:44];
    assign cg     = s_tdata[59:52];
    assign cr     = s_tdata[67:60];

    // effective region limits
    logic [LIM_W-1:0] rows_lim, cols_lim, row_w, col_w;
    logic             in_region, accept;

    always_comb begin
        rows_lim = (LIM_W'(rows_reg) > MAX_ROWS_L) ? MAX_ROWS_L : LIM_W'(rows_reg);
        cols_lim = (LIM_W'(cols_reg) > MAX_COLS_L) ? MAX_COLS_L : LIM_W'(cols_reg);
        row_w    = LIM_W'(in_row);
        col_w    = LIM_W'(in_col);
        in_region = (row_w < rows_lim) && (col_w < cols_lim);
    end

    // stage 1 registers (pair accepted, column entry being read)
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_mode_reg;
    logic              s1_start_reg;
    logic              s1_last_reg;
    logic [POS_W-1:0]  s1_row_reg, s1_col_reg;
    logic [SUM_W-1:0]  s1_sum_reg;
    logic              byp_hit_reg, byp_hit_next;
    peak_entry_t       byp_data_reg;

    // output register
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    // stage 1 moves unless it closes a line and the output is held
    logic s1_adv;
    assign s1_adv   = !s1_valid_reg || !s1_last_reg || !m_valid_reg || m_tready;
    assign s_tready = s1_adv;
    assign accept   = s_tvalid && s_tready;

    // row running peak
    logic [PEAK_W-1:0] row_peak_reg;
    logic [POS_W-1:0]  row_place_reg;

    // column store
    peak_entry_t       ram_rdata;
    peak_entry_t       new_entry;
    logic              ram_we;
    logic [CW-1:0]     ram_waddr, ram_raddr;
    logic [LIM_W-1:0]  s1_col_w;

    assign s1_col_w  = LIM_W'(s1_col_reg);
    assign ram_waddr = s1_col_w[CW-1:0];
    assign ram_raddr = col_w[CW-1:0];
    assign ram_we    = s1_valid_reg && s1_mode_reg && s1_adv;

    lpd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_COLS)
    ) u_col_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (new_entry),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // peak update: mean difference, base entry, strictly larger wins
    logic [PROD_W-1:0] prod;
    logic [PEAK_W-1:0] d;
    peak_entry_t       base;
    logic [POS_W-1:0]  pos_along;

    always_comb begin
        prod      = PROD_W'(s1_sum_reg) * PROD_W'(RECIP_3);
        d         = prod[RECIP_SHIFT +: PEAK_W];
        pos_along = s1_mode_reg ? s1_row_reg : s1_col_reg;
        if (s1_start_reg) begin
            base = '0;
        end else if (s1_mode_reg) begin
            base = byp_hit_reg ? byp_data_reg : ram_rdata;
        end else begin
            base.peak  = row_peak_reg;
            base.place = row_place_reg;
        end
        new_entry = base;
        if (d > base.peak) begin
            new_entry.peak  = d;
            new_entry.place = pos_along;
        end
    end

    // bypass hit: the pair now in stage 1 writes the column just read
    always_comb begin
        s1_valid_next = in_region;
        byp_hit_next  = in_region && mode_reg && s1_valid_reg && s1_mode_reg
                     && (s1_col_reg == in_col);
    end

    // stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= s1_valid_next;
            byp_hit_reg  <= byp_hit_next;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_mode_reg  <= mode_reg;
            s1_row_reg   <= in_row;
            s1_col_reg   <= in_col;
            s1_sum_reg   <= diff_sum(rb, rg, rr, cb, cg, cr);
            s1_start_reg <= mode_reg ? (in_row == '0) : (in_col == '0);
            s1_last_reg  <= mode_reg ? (row_w == rows_lim - 1'b1)
                                     : (col_w == cols_lim - 1'b1);
            byp_data_reg <= new_entry;
        end
    end

    // row running peak write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_peak_reg  <= '0;
            row_place_reg <= '0;
        end else if (s1_valid_reg && !s1_mode_reg && s1_adv) begin
            row_peak_reg  <= new_entry.peak;
            row_place_reg <= new_entry.place;
        end
    end

    // output register
    logic emit;
    assign emit = s1_valid_reg && s1_last_reg && s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= {4'b0, new_entry.place, new_entry.peak,
                           (s1_mode_reg ? s1_col_reg : s1_row_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    // a held result blocks a second line-closing pair
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_last_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("result register would be overwritten");

    // bypass is only armed for a column-mode pair in stage 1
    a_bypass_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        byp_hit_reg |-> (s1_valid_reg && s1_mode_reg))
        else $error("bypass armed without a column-mode pair");

    // reciprocal product stays within the eight-bit mean
    a_mean_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (prod[PROD_W-1] == 1'b0))
        else $error("mean difference out of range");

    // a zero peak always reports position zero
    a_zero_peak_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg[17:10] == '0)) |-> (m_data_reg[27:18] == '0))
        else $error("zero peak with nonzero position");
`endif

endmodule
